/* hw/rtl/tsb_pkg.sv */
// Package for the timer slot bank: bank size, command codes, and the
// structs that travel between the top level and the slot cells.
// No dependencies.
package tsb_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // cell ids must also cover the full 3-bit slot field of an unregister
  localparam int ID_W   = (SLOT_W > 3) ? SLOT_W : 3;
  localparam int N_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] MODE_REGISTER   = 3'd0;
  localparam logic [2:0] MODE_UNREGISTER = 3'd1;
  localparam logic [2:0] MODE_CLEAR      = 3'd2;
  localparam logic [2:0] MODE_TICK       = 3'd3;
  localparam logic [2:0] MODE_PROCESS    = 3'd4;

  // command broadcast to every cell
  typedef struct packed {
    logic            reg_en;
    logic            unreg_en;
    logic            clear_en;
    logic            tick_en;
    logic            kill;
    logic            single;
    logic [31:0]     period;
    logic [ID_W-1:0] slot;
  } tsb_cmd_t;

  // expiry report handed up the chain from the token cell
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [2:0] id;
  } tsb_hit_t;

endpackage

/* hw/rtl/tsb_cell.sv */
// One timer slot: active flag, count, period and one-shot flag, plus the
// neighbor links for allocation, the process scan token and expiry lookahead.
// Depends on tsb_pkg.
module tsb_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [tsb_pkg::ID_W-1:0] cell_id,
  input  tsb_pkg::tsb_cmd_t       cmd,
  // allocation chain, low slot to high slot
  input  logic                    free_in,
  output logic                    free_out,
  input  logic [tsb_pkg::ID_W-1:0] fid_in,
  output logic [tsb_pkg::ID_W-1:0] fid_out,
  // scan token, low slot to high slot
  input  logic                    tok_in,
  output logic                    tok_out,
  // expiry lookahead, high slot to low slot
  input  logic                    later_in,
  output logic                    later_out,
  // report chain, low slot to high slot
  input  tsb_pkg::tsb_hit_t       hit_in,
  output tsb_pkg::tsb_hit_t       hit_out
);
  import tsb_pkg::*;

  logic        active_r, active_nxt;
  logic        tok_r;
  logic        single_r;
  logic [31:0] count_r, count_nxt;
  logic [31:0] period_r;
  logic        expired;
  logic        claim;
  logic        emit;

  assign expired   = active_r && (count_r >= period_r);
  assign claim     = cmd.reg_en && !active_r && !free_in;
  assign emit      = tok_r && expired;

  assign free_out  = free_in || !active_r;
  assign fid_out   = (!free_in && !active_r) ? cell_id : fid_in;
  assign tok_out   = tok_r;
  assign later_out = later_in || expired;

  always_comb begin
    hit_out = hit_in;
    if (emit) begin
      hit_out.emit = 1'b1;
      hit_out.last = !later_in;
      hit_out.id   = cell_id[2:0];
    end
  end

  always_comb begin
    active_nxt = active_r;
    count_nxt  = count_r;
    if (claim) begin
      active_nxt = 1'b1;
      count_nxt  = '0;
    end
    if (cmd.unreg_en && (cmd.slot == cell_id)) begin
      active_nxt = 1'b0;
    end
    if (cmd.clear_en) begin
      active_nxt = 1'b0;
    end
    if (cmd.tick_en && active_r && (count_r != '1)) begin
      count_nxt = count_r + 32'd1;
    end
    if (emit) begin
      count_nxt = '0;
      if (single_r) active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tok_r    <= 1'b0;
    end else begin
      active_r <= active_nxt;
      tok_r    <= tok_in && !cmd.kill;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    if (claim) begin
      period_r <= cmd.period;
      single_r <= cmd.single;
    end
  end

endmodule

/* hw/rtl/timer_slot_bank.sv */
// Timer slot bank top level: command decode, result register and the
// process scan control around a chain of tsb_cell slots.
// Depends on tsb_pkg and tsb_cell.
//
// Usage:
//   A request is taken at a clock edge with start high and busy low. in_mode
//   selects register, unregister, clear, tick or process; in_period and
//   in_single go with register, in_slot with unregister.
//   Register and unregister give one result, on out_* with out_valid high
//   for one cycle, in the cycle after the request. Clear and tick give no
//   result and busy stays low, so a request may follow in the next cycle.
//   Process raises busy and passes a scan token along the slots, one slot
//   per cycle, lowest first, each expired slot reported in the cycle after
//   the token visits it. The scan stops after the final report, marked by
//   out_last; busy falls in the same cycle as that report, or as the token
//   leaves the top slot.
//   Results cannot be held off; there is no output backpressure.
//   Reset frees every slot and aborts a scan; slot contents are not cleared.
module timer_slot_bank (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_mode,
  input  logic [31:0] in_period,
  input  logic       in_single,
  input  logic [2:0] in_slot,
  output logic       out_valid,
  output logic [2:0] out_slot_id,
  output logic       out_status,
  output logic       out_fired,
  output logic       out_last
);
  import tsb_pkg::*;

  logic            accept;
  logic            proc_start;
  tsb_cmd_t        cmd;
  logic            busy_r, busy_nxt;
  logic [N_W-1:0]  n_r, n_nxt;
  logic            cap;
  logic            hit_last;
  logic            full;
  logic            unreg_bad;
  logic            out_valid_r;
  logic [2:0]      out_slot_id_r;
  logic            out_status_r, out_fired_r, out_last_r;
  logic [SLOTS-1:0] tok_vec;

  logic            free_c  [SLOTS+1];
  logic [ID_W-1:0] fid_c   [SLOTS+1];
  logic            tok_c   [SLOTS+1];
  logic            later_c [SLOTS+1];
  tsb_hit_t        hit_c   [SLOTS+1];

  assign accept     = start && !busy_r;
  assign proc_start = accept && (in_mode == MODE_PROCESS);

  assign cap      = (n_r == N_W'(MAX_RESULTS - 1));
  assign hit_last = hit_c[SLOTS].last || cap;

  always_comb begin
    cmd          = '0;
    cmd.reg_en   = accept && (in_mode == MODE_REGISTER);
    cmd.unreg_en = accept && (in_mode == MODE_UNREGISTER);
    cmd.clear_en = accept && (in_mode == MODE_CLEAR);
    cmd.tick_en  = accept && (in_mode == MODE_TICK);
    cmd.kill     = hit_c[SLOTS].emit && hit_last;
    cmd.single   = in_single;
    cmd.period   = in_period;
    cmd.slot     = ID_W'(in_slot);
  end

  assign free_c[0]      = 1'b0;
  assign fid_c[0]       = '0;
  assign tok_c[0]       = proc_start;
  assign later_c[SLOTS] = 1'b0;
  assign hit_c[0]       = '0;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      tsb_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_id   (ID_W'(g)),
        .cmd       (cmd),
        .free_in   (free_c[g]),
        .free_out  (free_c[g+1]),
        .fid_in    (fid_c[g]),
        .fid_out   (fid_c[g+1]),
        .tok_in    (tok_c[g]),
        .tok_out   (tok_c[g+1]),
        .later_in  (later_c[g+1]),
        .later_out (later_c[g]),
        .hit_in    (hit_c[g]),
        .hit_out   (hit_c[g+1])
      );
      assign tok_vec[g] = tok_c[g+1];
    end
  endgenerate

  assign full      = !free_c[SLOTS];
  assign unreg_bad = (32'(in_slot) >= 32'(SLOTS));

  always_comb begin
    busy_nxt = busy_r;
    n_nxt    = n_r;
    if (proc_start) begin
      busy_nxt = 1'b1;
      n_nxt    = '0;
    end else begin
      if (tok_vec[SLOTS-1] || cmd.kill) busy_nxt = 1'b0;
      if (hit_c[SLOTS].emit) n_nxt = n_r + N_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      n_r         <= n_nxt;
      out_valid_r <= cmd.reg_en || cmd.unreg_en || hit_c[SLOTS].emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reg_en) begin
      out_slot_id_r <= full ? 3'd0 : fid_c[SLOTS][2:0];
      out_status_r  <= full;
      out_fired_r   <= 1'b0;
      out_last_r    <= 1'b1;
    end else if (cmd.unreg_en) begin
      out_slot_id_r <= in_slot;
      out_status_r  <= unreg_bad;
      out_fired_r   <= 1'b0;
      out_last_r    <= 1'b1;
    end else begin
      out_slot_id_r <= hit_c[SLOTS].id;
      out_status_r  <= 1'b0;
      out_fired_r   <= 1'b1;
      out_last_r    <= hit_last;
    end
  end

  assign busy        = busy_r;
  assign out_valid   = out_valid_r;
  assign out_slot_id = out_slot_id_r;
  assign out_status  = out_status_r;
  assign out_fired   = out_fired_r;
  assign out_last    = out_last_r;

`ifndef NO_ASSERTIONS
  // a scan is running exactly while one token sits in the chain
  a_busy_tok : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (|tok_vec))
    else $error("busy flag and scan token disagree");

  a_tok_one : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one scan token");

  // expiry reports only come out of a scan
  a_fired_scan : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fired_r |-> $past(busy_r))
    else $error("expiry report outside a process scan");

  // the final report ends the scan
  a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fired_r && out_last_r |-> !busy_r)
    else $error("scan continues after final report");
`endif

endmodule

/* bench/tb_timer_slot_bank.sv */
// Self-checking bench for timer_slot_bank: directed and random requests,
// predicted per request against a shadow of the slot bank.
// Depends on tsb_pkg and the timer_slot_bank RTL.
module tb_timer_slot_bank;
  import tsb_pkg::*;

  localparam int LIMIT = 200000;
  localparam int N_RANDOM = 350;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] period;
    logic        single;
    logic [2:0]  slot;
    bit          hold;       // wait for an empty bank pipeline before issuing
    int unsigned idle_pct;
  } tmr_cmd_t;

  typedef struct {
    logic [2:0] slot_id;
    logic       status;
    logic       fired;
    logic       last;
  } tmr_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  in_mode = MODE_TICK;
  logic [31:0] in_period = '0;
  logic        in_single = 1'b0;
  logic [2:0]  in_slot = '0;
  logic        busy;
  logic        out_valid;
  logic [2:0]  out_slot_id;
  logic        out_status;
  logic        out_fired;
  logic        out_last;

  // shadow of the slot bank
  bit        slot_on[SLOTS];
  bit [31:0] slot_ticks[SLOTS];
  bit [31:0] slot_limit[SLOTS];
  bit        slot_once[SLOTS];

  tmr_cmd_t    cmd_q[$];
  tmr_cmd_t    cur_cmd;
  tmr_report_t pending_reports[$];

  int n_errors = 0;
  int n_cycles = 0;
  int n_reports = 0;
  int n_expiries = 0;
  int n_full = 0;
  int n_by_mode[8];

  timer_slot_bank i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_period  (in_period),
    .in_single  (in_single),
    .in_slot    (in_slot),
    .out_valid  (out_valid),
    .out_slot_id(out_slot_id),
    .out_status (out_status),
    .out_fired  (out_fired),
    .out_last   (out_last)
  );

  always #1 clk = ~clk;

  function automatic void add_report(logic [2:0] id, logic st, logic fi, logic la);
    tmr_report_t r;
    r.slot_id = id;
    r.status  = st;
    r.fired   = fi;
    r.last    = la;
    pending_reports.push_back(r);
  endfunction

  // apply one accepted request to the shadow bank, queue what it must report
  function automatic void bank_apply(tmr_cmd_t c);
    bit found;
    int n;
    found = 0;
    n = 0;
    n_by_mode[c.mode]++;
    case (c.mode)
      MODE_REGISTER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !slot_on[i]) begin
            found = 1;
            slot_on[i]    = 1'b1;
            slot_ticks[i] = '0;
            slot_limit[i] = c.period;
            slot_once[i]  = c.single;
            add_report(i[2:0], 1'b0, 1'b0, 1'b1);
          end
        end
        if (!found) begin
          n_full++;
          add_report(3'd0, 1'b1, 1'b0, 1'b1);
        end
      end
      MODE_UNREGISTER: begin
        if (c.slot < SLOTS) begin
          slot_on[c.slot] = 1'b0;
          add_report(c.slot, 1'b0, 1'b0, 1'b1);
        end else begin
          add_report(c.slot, 1'b1, 1'b0, 1'b1);
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_on[i] = 1'b0;
      end
      MODE_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_on[i] && slot_ticks[i] != 32'hFFFF_FFFF) slot_ticks[i]++;
      end
      MODE_PROCESS: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (n < MAX_RESULTS && slot_on[i] && slot_ticks[i] >= slot_limit[i]) begin
            slot_ticks[i] = '0;
            if (slot_once[i]) slot_on[i] = 1'b0;
            add_report(i[2:0], 1'b0, 1'b1, 1'b0);
            n++;
          end
        end
        if (n > 0) pending_reports[pending_reports.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_cmd(logic [2:0] mode, logic [31:0] period, logic single,
                                   logic [2:0] slot, bit hold, int unsigned idle_pct);
    tmr_cmd_t c;
    c.mode     = mode;
    c.period   = period;
    c.single   = single;
    c.slot     = slot;
    c.hold     = hold;
    c.idle_pct = idle_pct;
    cmd_q.push_back(c);
  endfunction

  // mostly small periods so slots actually expire; ticks and processes dominate
  function automatic void push_random(bit hold, int unsigned idle_pct);
    int unsigned pick;
    int unsigned psel;
    logic [2:0]  mode;
    logic [31:0] period;
    pick = $urandom_range(99);
    psel = $urandom_range(99);
    if (pick < 22)      mode = MODE_REGISTER;
    else if (pick < 34) mode = MODE_UNREGISTER;
    else if (pick < 37) mode = MODE_CLEAR;
    else if (pick < 68) mode = MODE_TICK;
    else if (pick < 95) mode = MODE_PROCESS;
    else                mode = 3'($urandom_range(7, 5));
    if (psel < 50)      period = $urandom_range(4);
    else if (psel < 75) period = $urandom_range(12);
    else if (psel < 92) period = $urandom;
    else                period = 32'hFFFF_FFFF;
    push_cmd(mode, period, 1'($urandom_range(1)), 3'($urandom_range(7)), hold, idle_pct);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) bank_apply(cur_cmd);
      if (cmd_q.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_q[0].hold && (start || busy || pending_reports.size() != 0)) begin
        start <= 1'b0;
      end else if ($urandom_range(99) < cmd_q[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        cur_cmd = cmd_q.pop_front();
        start       <= 1'b1;
        in_mode     <= cur_cmd.mode;
        in_period   <= cur_cmd.period;
        in_single   <= cur_cmd.single;
        in_slot     <= cur_cmd.slot;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    tmr_report_t e;
    if (rst_n && out_valid) begin
      n_reports++;
      if (out_fired) n_expiries++;
      if (pending_reports.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected result slot_id=%0d status=%0b fired=%0b last=%0b",
                   out_slot_id, out_status, out_fired, out_last);
      end else begin
        e = pending_reports.pop_front();
        if (out_slot_id !== e.slot_id || out_status !== e.status ||
            out_fired !== e.fired || out_last !== e.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result exp id=%0d st=%0b fi=%0b la=%0b got id=%0d st=%0b fi=%0b la=%0b",
                     e.slot_id, e.status, e.fired, e.last,
                     out_slot_id, out_status, out_fired, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT) begin
      $display("TIMEOUT after %0d cycles", n_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned idle_by_phase[4];
    idle_by_phase = '{0, 56, 0, 23};
    for (int i = 0; i < SLOTS; i++) begin
      slot_on[i]    = 1'b0;
      slot_ticks[i] = '0;
      slot_limit[i] = '0;
      slot_once[i]  = 1'b0;
    end
    for (int m = 0; m < 8; m++) n_by_mode[m] = 0;

    // directed: fill the bank with extreme periods, then overflow it
    push_cmd(MODE_REGISTER, 32'h0000_0000, 1'b0, 3'd7, 0, 0);
    push_cmd(MODE_REGISTER, 32'h0000_0001, 1'b1, 3'd0, 0, 0);
    push_cmd(MODE_REGISTER, 32'hFFFF_FFFF, 1'b0, 3'd5, 0, 0);
    push_cmd(MODE_REGISTER, 32'h0000_0002, 1'b1, 3'd2, 0, 0);
    push_cmd(MODE_REGISTER, 32'h8000_0000, 1'b0, 3'd0, 0, 0);
    push_cmd(MODE_REGISTER, 32'h0000_0003, 1'b0, 3'd0, 0, 0);
    push_cmd(MODE_REGISTER, 32'h5555_5555, 1'b1, 3'd0, 0, 0);
    push_cmd(MODE_REGISTER, 32'hAAAA_AAAA, 1'b0, 3'd0, 0, 0);
    push_cmd(MODE_REGISTER, 32'h0000_0004, 1'b0, 3'd0, 0, 0);
    push_cmd(MODE_PROCESS,  32'hFFFF_FFFF, 1'b1, 3'd7, 0, 0);
    push_cmd(MODE_TICK,     32'h0,         1'b0, 3'd0, 0, 0);
    push_cmd(MODE_TICK,     32'h0,         1'b0, 3'd0, 0, 0);
    push_cmd(MODE_PROCESS,  32'h0,         1'b0, 3'd0, 0, 0);
    // slot zero, then freeing an already free slot
    push_cmd(MODE_UNREGISTER, 32'h0,       1'b0, 3'd0, 0, 0);
    push_cmd(MODE_UNREGISTER, 32'h0,       1'b0, 3'd0, 0, 0);
    push_cmd(MODE_UNREGISTER, 32'hFFFF_FFFF, 1'b1, 3'd7, 0, 0);
    push_cmd(MODE_REGISTER, 32'h0000_0001, 1'b0, 3'd0, 0, 0);
    // unused mode codes must do nothing
    push_cmd(3'd5, 32'h0000_0000, 1'b0, 3'd0, 0, 0);
    push_cmd(3'd6, 32'hFFFF_FFFF, 1'b1, 3'd7, 0, 0);
    push_cmd(3'd7, 32'h1234_5678, 1'b1, 3'd3, 0, 0);
    push_cmd(MODE_TICK,     32'h0,         1'b0, 3'd0, 0, 0);
    push_cmd(MODE_PROCESS,  32'h0,         1'b0, 3'd0, 0, 0);
    push_cmd(MODE_CLEAR,    32'h0,         1'b0, 3'd0, 0, 0);
    push_cmd(MODE_PROCESS,  32'h0,         1'b0, 3'd0, 0, 0);
    push_cmd(MODE_UNREGISTER, 32'h0,       1'b0, 3'd5, 0, 0);

    // random phases; each starts only after the previous one has drained
    for (int p = 0; p < 4; p++)
      for (int k = 0; k < N_RANDOM / 4; k++)
        push_random(k == 0, idle_by_phase[p]);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || start || busy || pending_reports.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);

    if (pending_reports.size() != 0) begin
      n_errors += pending_reports.size();
      $display("ERROR: %0d expected results never arrived", pending_reports.size());
    end
    $display("Covered: %0d register, %0d unregister, %0d clear, %0d tick, %0d process, %0d other",
             n_by_mode[MODE_REGISTER], n_by_mode[MODE_UNREGISTER], n_by_mode[MODE_CLEAR],
             n_by_mode[MODE_TICK], n_by_mode[MODE_PROCESS],
             n_by_mode[5] + n_by_mode[6] + n_by_mode[7]);
    $display("Results: %0d checked, %0d expiries, %0d bank-full rejects, %0d errors",
             n_reports, n_expiries, n_full, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
